>>> hw/rtl/chkv_pkg.sv
// Package with request and response types and operation codes for the chained hash table.
`default_nettype none
package chkv_pkg;

  // Operation codes carried in the kind field.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam int unsigned CFG_BITS = 11;
  localparam logic [CFG_BITS-1:0] BUCKET_COUNT_RESET = 11'd1021;

  // One request.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  // One response.
  typedef struct packed {
    logic        status;
    logic        found;
    logic [31:0] data_out;
  } rsp_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_HEAD_RD,
    ST_HEAD_WAIT,
    ST_NODE_RD,
    ST_NODE_WAIT,
    ST_DECIDE,
    ST_INS_NEW,
    ST_INS_LINK,
    ST_REM_FIX,
    ST_CLEAR,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/chained_hash_key_value_table.sv
// Top level of the chained hash key/value table: sequencer, bucket memory and node pool.
// Each request takes a restoring key modulo, a bucket head read and a walk of the chain;
// a new insert then pops a free node and links it at the head, and a remove of a present
// key unlinks it and pushes it onto the free stack.
// Throughput: one request at a time; busy falls in the cycle of the result strobe.
// Reset: synchronous; then a clearing pass empties all MAX_BUCKETS bucket heads while
// busy is high. The free stack starts full. Results cannot be stalled.
`default_nettype none
module chained_hash_key_value_table #(
  parameter int unsigned MAX_BUCKETS  = 1024,
  parameter int unsigned POOL_ENTRIES = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire chkv_pkg::req_t                req,
  output logic                               done,
  output chkv_pkg::rsp_t                     rsp,
  input  wire logic                          cfg_we,
  input  wire logic [chkv_pkg::CFG_BITS-1:0] cfg_data
);

  localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned NW = $clog2(POOL_ENTRIES);
  localparam int unsigned PW = NW + 1; // node pointer with null
  localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);
  localparam logic [PW-1:0] POOL_FULL = PW'(POOL_ENTRIES);

  // Memories.
  logic [PW-1:0] head_mem [MAX_BUCKETS];
  logic [31:0]   key_mem  [POOL_ENTRIES];
  logic [31:0]   val_mem  [POOL_ENTRIES];
  logic [PW-1:0] next_mem [POOL_ENTRIES];
  logic [PW-1:0] prev_mem [POOL_ENTRIES];
  logic [NW-1:0] free_mem [POOL_ENTRIES];

  chkv_pkg::state_t state, state_next;
  logic [chkv_pkg::CFG_BITS-1:0] bucket_count;
  chkv_pkg::req_t cur;
  logic [BW-1:0]  bucket;
  logic [PW-1:0]  node;
  logic [PW-1:0]  nprev, nnext;
  logic [31:0]    nkey, nval;
  logic [PW-1:0]  head_q;
  logic [PW-1:0]  free_count;
  logic [PW-1:0]  free_init;
  logic [NW-1:0]  free_q;
  logic [PW:0]    steps;
  logic [BW:0]    clr;
  logic [5:0]     div_cnt;
  logic [31:0]    div_q;
  logic [BW:0]    div_r;
  logic [BW:0]    divisor;
  logic [BW+1:0]  trial;
  chkv_pkg::rsp_t rsp_next;
  logic           rsp_ok;

  // Effective divisor: zero means one, large values saturate.
  always_comb begin
    priority if (bucket_count == '0) divisor = (BW+1)'(1);
    else if (32'(bucket_count) > MAX_BUCKETS) divisor = (BW+1)'(MAX_BUCKETS);
    else divisor = (BW+1)'(bucket_count);
    trial = {div_r, div_q[31]} - {1'b0, divisor};
  end

  assign busy = (state != chkv_pkg::ST_IDLE);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) bucket_count <= chkv_pkg::BUCKET_COUNT_RESET;
    else if (cfg_we) bucket_count <= cfg_data;
  end

  // Free stack: entries below free_init are implicitly their own index.
  always_ff @(posedge clk) begin
    free_q <= free_mem[free_count[NW-1:0] - NW'(1)];
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) state <= chkv_pkg::ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      chkv_pkg::ST_IDLE:      if (start) state_next = chkv_pkg::ST_MOD;
      chkv_pkg::ST_MOD:       if (div_cnt == 6'd32) state_next = chkv_pkg::ST_HEAD_RD;
      chkv_pkg::ST_HEAD_RD:   state_next = chkv_pkg::ST_HEAD_WAIT;
      chkv_pkg::ST_HEAD_WAIT: state_next = chkv_pkg::ST_NODE_RD;
      chkv_pkg::ST_NODE_RD: begin
        if (node == NIL || steps[PW-1:0] == POOL_FULL) state_next = chkv_pkg::ST_DECIDE;
        else state_next = chkv_pkg::ST_NODE_WAIT;
      end
      chkv_pkg::ST_NODE_WAIT: begin
        if (nkey == cur.key) state_next = chkv_pkg::ST_DECIDE;
        else state_next = chkv_pkg::ST_NODE_RD;
      end
      chkv_pkg::ST_DECIDE: begin
        priority if (cur.kind == chkv_pkg::KIND_INSERT && node == NIL && free_count != '0)
          state_next = chkv_pkg::ST_INS_NEW;
        else if (cur.kind == chkv_pkg::KIND_REMOVE && node != NIL)
          state_next = chkv_pkg::ST_REM_FIX;
        else state_next = chkv_pkg::ST_DONE;
      end
      chkv_pkg::ST_INS_NEW:   state_next = chkv_pkg::ST_INS_LINK;
      chkv_pkg::ST_INS_LINK:  state_next = chkv_pkg::ST_DONE;
      chkv_pkg::ST_REM_FIX:   state_next = chkv_pkg::ST_DONE;
      chkv_pkg::ST_CLEAR:     if (clr == (BW+1)'(MAX_BUCKETS - 1)) state_next = chkv_pkg::ST_IDLE;
      chkv_pkg::ST_DONE:      state_next = chkv_pkg::ST_IDLE;
      default:                state_next = chkv_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory accesses.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= '0;
      free_count <= POOL_FULL;
      free_init  <= POOL_FULL;
      rsp_ok     <= 1'b0;
    end else begin
      rsp_ok <= 1'b0;
      unique case (state)
        chkv_pkg::ST_CLEAR: begin
          head_mem[clr[BW-1:0]] <= NIL;
          clr <= clr + 1'b1;
        end
        chkv_pkg::ST_IDLE: if (start) begin
          cur     <= req;
          div_q   <= req.key;
          div_r   <= '0;
          div_cnt <= '0;
          steps   <= '0;
        end
        chkv_pkg::ST_MOD: if (div_cnt != 6'd32) begin
          // One restoring step per cycle.
          if (!trial[BW+1]) div_r <= trial[BW:0];
          else div_r <= {div_r[BW-1:0], div_q[31]};
          div_q   <= {div_q[30:0], 1'b0};
          div_cnt <= div_cnt + 1'b1;
        end else bucket <= div_r[BW-1:0];
        chkv_pkg::ST_HEAD_RD: head_q <= head_mem[bucket];
        chkv_pkg::ST_HEAD_WAIT: node <= head_q;
        chkv_pkg::ST_NODE_RD: if (node != NIL) begin
          nkey  <= key_mem[node[NW-1:0]];
          nval  <= val_mem[node[NW-1:0]];
          nnext <= next_mem[node[NW-1:0]];
          nprev <= prev_mem[node[NW-1:0]];
          steps <= steps + 1'b1;
        end
        chkv_pkg::ST_NODE_WAIT: if (nkey != cur.key) node <= nnext;
        chkv_pkg::ST_DECIDE: begin
          if (cur.kind == chkv_pkg::KIND_INSERT && node != NIL)
            val_mem[node[NW-1:0]] <= cur.value;
        end
        chkv_pkg::ST_INS_NEW: begin
          // Pop a free node; untouched stack entries hold their own index.
          node <= (free_count <= free_init) ? free_count - 1'b1 : {1'b0, free_q};
          free_count <= free_count - 1'b1;
          if (free_count <= free_init) free_init <= free_count - 1'b1;
        end
        chkv_pkg::ST_INS_LINK: begin
          key_mem[node[NW-1:0]]  <= cur.key;
          val_mem[node[NW-1:0]]  <= cur.value;
          prev_mem[node[NW-1:0]] <= NIL;
          next_mem[node[NW-1:0]] <= head_q;
          if (head_q != NIL) prev_mem[head_q[NW-1:0]] <= node;
          head_mem[bucket] <= node;
        end
        chkv_pkg::ST_REM_FIX: begin
          if (nprev != NIL) next_mem[nprev[NW-1:0]] <= nnext;
          else head_mem[bucket] <= nnext;
          if (nnext != NIL) prev_mem[nnext[NW-1:0]] <= nprev;
          free_mem[free_count[NW-1:0]] <= node[NW-1:0];
          free_count <= free_count + 1'b1;
        end
        chkv_pkg::ST_DONE: rsp_ok <= 1'b1;
        default: ;
      endcase
    end
  end

  // Response formed from the search result.
  always_comb begin
    rsp_next = '0;
    if (cur.kind <= chkv_pkg::KIND_LOOKUP) rsp_next.found = (node != NIL);
    if (cur.kind == chkv_pkg::KIND_INSERT && node == NIL && free_count == '0)
      rsp_next.status = 1'b1;
    if (cur.kind == chkv_pkg::KIND_LOOKUP && node != NIL) rsp_next.data_out = nval;
  end

  // Capture the response once the search is decided.
  always_ff @(posedge clk) begin
    if (state == chkv_pkg::ST_DECIDE) rsp <= rsp_next;
  end

  assign done = rsp_ok;

endmodule
`default_nettype wire

>>> hw/rtl/chkv_checker.sv
// Port-level checker for the chained hash table, bound to the top level.
`default_nettype none
module chkv_port_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // A result only follows an operation that kept the block busy.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without busy");

  // The strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // Accepting a request makes the block busy.
  a_accept: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // The block is already idle in the cycle of the result strobe.
  a_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy while reporting result");

endmodule

bind chained_hash_key_value_table chkv_port_checker u_chkv_port_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
`default_nettype wire
